// ===== rtl/core/osts_pkg.sv =====
package osts_pkg;

    localparam int KIND_W   = 2;
    localparam int TIME_W   = 48;
    localparam int DELAY_W  = 32;
    localparam int TAG_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SCHEDULED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;

    typedef struct packed {
        logic                load_in;
        logic                sched_wr;
        logic                clear_all;
        logic                rd_en;
        logic                fire_clr;
        logic                pend_load;
        logic                pend_clr;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } osts_cmd_t;

    typedef struct packed {
        logic free_found;
        logic hit;
        logic out_busy;
        logic pend_valid;
    } osts_sts_t;

endpackage

// ===== rtl/core/osts_dpath.sv =====
module osts_dpath
    import osts_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  osts_cmd_t             cmd,
    input  logic [IDX_W-1:0]      rd_addr,
    input  logic [IDX_W-1:0]      chk_idx,
    output osts_sts_t             sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast
);

    logic [TIME_W-1:0]  now_in;
    logic signed [DELAY_W-1:0] delay_in;
    logic [TAG_W-1:0]   tag_in;
    logic signed [TIME_W+1:0] sum;
    logic [TIME_W-1:0]  fire_next;

    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  fire_reg;
    logic [TAG_W-1:0]   tag_reg;

    logic [SLOTS-1:0]   active_reg;
    logic [SLOTS-1:0]   active_next;
    logic [TIME_W-1:0]  fire_mem_reg [SLOTS];
    logic [TAG_W-1:0]   tag_mem_reg [SLOTS];
    logic [TIME_W-1:0]  rd_fire_reg;
    logic [TAG_W-1:0]   rd_tag_reg;

    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               hit;

    logic               pend_valid_reg;
    logic [IDX_W-1:0]   pend_slot_reg;
    logic [TAG_W-1:0]   pend_tag_reg;

    logic               m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic               out_last_reg;
    logic [SLOT_W-1:0]  out_slot_next;
    logic [TAG_W-1:0]   out_tag_next;

    assign now_in   = s_tdata[TIME_W-1:0];
    assign delay_in = s_tdata[TIME_W+DELAY_W-1:TIME_W];
    assign tag_in   = s_tdata[TIME_W+DELAY_W+TAG_W-1:TIME_W+DELAY_W];

    // saturate now + delay to the time range
    always_comb
    begin
        sum = signed'({2'b00, now_in}) + (TIME_W+2)'(delay_in);
        if (sum[TIME_W+1])
            fire_next = '0;
        else if (sum[TIME_W])
            fire_next = '1;
        else
            fire_next = sum[TIME_W-1:0];
    end

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign hit = active_reg[chk_idx] && (rd_fire_reg <= now_reg);

    always_comb
    begin
        active_next = active_reg;
        if (cmd.clear_all)
            active_next = '0;
        else if (cmd.sched_wr)
            active_next[free_idx] = 1'b1;
        else if (cmd.fire_clr)
            active_next[chk_idx] = 1'b0;
    end

    always_comb
    begin
        out_slot_next = '0;
        out_tag_next  = '0;
        if (cmd.out_status == ST_FIRED)
        begin
            out_slot_next = SLOT_W'(pend_slot_reg);
            out_tag_next  = pend_tag_reg;
        end
        else if (cmd.out_status == ST_SCHEDULED)
        begin
            out_slot_next = SLOT_W'(free_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            if (cmd.pend_clr)
                pend_valid_reg <= 1'b0;
            else if (cmd.pend_load)
                pend_valid_reg <= 1'b1;
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg  <= now_in;
            fire_reg <= fire_next;
            tag_reg  <= tag_in;
        end
        if (cmd.pend_load)
        begin
            pend_slot_reg <= chk_idx;
            pend_tag_reg  <= rd_tag_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_slot_reg   <= out_slot_next;
            out_tag_reg    <= out_tag_next;
            out_last_reg   <= cmd.out_last;
        end
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (cmd.sched_wr)
        begin
            fire_mem_reg[free_idx] <= fire_reg;
            tag_mem_reg[free_idx]  <= tag_reg;
        end
        if (cmd.rd_en)
        begin
            rd_fire_reg <= fire_mem_reg[rd_addr];
            rd_tag_reg  <= tag_mem_reg[rd_addr];
        end
    end

    assign sts.free_found = free_found;
    assign sts.hit        = hit;
    assign sts.out_busy   = m_tvalid_reg && !m_tready;
    assign sts.pend_valid = pend_valid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_tag_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_sched_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sched_wr |-> free_found)
        else $error("schedule write with no free slot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten while stalled");

    a_fire_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire_clr |-> hit)
        else $error("slot freed without a hit");

    a_cancel_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_all |=> (active_reg == '0))
        else $error("cancel all left a slot active");

endmodule

// ===== rtl/core/osts_ctrl.sv =====
module osts_ctrl
    import osts_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KIND_W-1:0] in_kind,
    input  osts_sts_t         sts,
    output osts_cmd_t         cmd,
    output logic [IDX_W-1:0]  rd_addr,
    output logic [IDX_W-1:0]  chk_idx
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCHED    = 3'd1;
    localparam logic [2:0] S_TICK_CHK = 3'd2;
    localparam logic [2:0] S_TICK_END = 3'd3;
    localparam logic [2:0] S_CANCEL   = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign chk_idx  = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_addr    = '0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    case (in_kind)
                        KIND_SCHEDULE: state_next = S_SCHED;
                        KIND_TICK:
                        begin
                            cmd.rd_en  = 1'b1;
                            idx_next   = '0;
                            state_next = S_TICK_CHK;
                        end
                        KIND_CANCEL:   state_next = S_CANCEL;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_SCHED:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (sts.free_found)
                    begin
                        cmd.sched_wr   = 1'b1;
                        cmd.out_status = ST_SCHEDULED;
                    end
                    else
                    begin
                        cmd.out_status = ST_DROPPED;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK_CHK:
            begin
                // a held fire goes out once the next one shows it is not the last
                if (!(sts.hit && sts.pend_valid && sts.out_busy))
                begin
                    if (sts.hit)
                    begin
                        cmd.fire_clr  = 1'b1;
                        cmd.pend_load = 1'b1;
                        if (sts.pend_valid)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_FIRED;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_TICK_END;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg + IDX_W'(1);
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_TICK_END:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (sts.pend_valid)
                    begin
                        cmd.out_status = ST_FIRED;
                        cmd.pend_clr   = 1'b1;
                    end
                    else
                    begin
                        cmd.out_status = ST_NONE_DUE;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CANCEL:
            begin
                if (!sts.out_busy)
                begin
                    cmd.clear_all  = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = ST_CANCELLED;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/core/one_shot_timer_slot_table.sv =====
// one-shot timer slot table
// slave side: one beat per request; tuser carries the kind (schedule, tick,
// cancel all), tdata carries now_time, delay and tag
// master side: result beats; tuser carries the status, tdata the slot and the
// fired tag, tlast marks the final result of a request
// schedule and cancel all give one result, loaded once the output register is free
// a tick reads one slot per cycle from the slot memory while the scan is not
// halted by a stall, then gives its final result; fired slots come out in
// ascending order, each held back one step so that tlast can be set
// a new request is taken once the previous one has loaded its final result,
// even while that result still waits on the master side
// reset frees every slot and empties the output register
// when the receiver stalls, the result stays in the output register; a tick
// scan halts at a further due slot until the register frees up
module one_shot_timer_slot_table
    import osts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // now_time, delay, tag
    input  logic [KIND_W-1:0]     s_tuser,  // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // slot, fired_tag, zero pad
    output logic [STATUS_W-1:0]   m_tuser,  // status
    output logic                  m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    osts_cmd_t        cmd;
    osts_sts_t        sts;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] chk_idx;

    osts_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_kind  (s_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .chk_idx  (chk_idx)
    );

    osts_dpath #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .chk_idx  (chk_idx),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/sv/one_shot_timer_slot_table_test.sv =====
module one_shot_timer_slot_table_test;
    import osts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int RANDOM_REQUESTS = 350;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [TAG_W-1:0]    tag;
        logic                last;
    } timer_result_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [TIME_W-1:0]   now;
        logic [DELAY_W-1:0]  delay;
        logic [TAG_W-1:0]    tag;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } request_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    // predictor copy of the slot table
    bit                    slot_busy [SLOTS];
    logic [TIME_W-1:0]     slot_due [SLOTS];
    logic [TAG_W-1:0]      slot_handle [SLOTS];

    timer_result_t         due_results[$];
    request_row_t          directed_rows[$];
    int                    fail_count;
    int                    beats_seen;
    bit                    send_burst;

    one_shot_timer_slot_table #(
        .SLOTS(SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [TIME_W-1:0] fire_time(input logic [TIME_W-1:0] now,
                                                    input logic [DELAY_W-1:0] delay);
        longint sum;
        sum = $signed({16'd0, now}) + $signed(delay);
        if (sum < 0)
            return '0;
        if (sum > $signed({16'd0, TIME_MAX}))
            return TIME_MAX;
        return sum[TIME_W-1:0];
    endfunction

    task automatic push_result(input logic [STATUS_W-1:0] status, input int slot,
                               input logic [TAG_W-1:0] tag, input logic last);
        timer_result_t r;
        r.status = status;
        r.slot   = slot[SLOT_W-1:0];
        r.tag    = tag;
        r.last   = last;
        due_results.push_back(r);
    endtask

    task automatic predict_table(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                                 input logic [DELAY_W-1:0] delay,
                                 input logic [TAG_W-1:0] tag);
        int fired;
        bit placed;
        fired  = 0;
        placed = 0;
        case (kind)
            KIND_SCHEDULE:
            begin
                for (int i = 0; i < SLOTS && !placed; i++)
                begin
                    if (!slot_busy[i])
                    begin
                        slot_busy[i]   = 1'b1;
                        slot_due[i]    = fire_time(now, delay);
                        slot_handle[i] = tag;
                        push_result(ST_SCHEDULED, i, '0, 1'b1);
                        placed = 1;
                    end
                end
                if (!placed)
                    push_result(ST_DROPPED, 0, '0, 1'b1);
            end
            KIND_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_busy[i] && slot_due[i] <= now)
                    begin
                        slot_busy[i] = 1'b0;
                        push_result(ST_FIRED, i, slot_handle[i], 1'b0);
                        fired++;
                    end
                end
                if (fired == 0)
                    push_result(ST_NONE_DUE, 0, '0, 1'b1);
                else
                    due_results[due_results.size()-1].last = 1'b1;
            end
            KIND_CANCEL:
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_busy[i] = 1'b0;
                push_result(ST_CANCELLED, 0, '0, 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                                input logic [DELAY_W-1:0] delay, input logic [TAG_W-1:0] tag,
                                input bit typed, input logic [STATUS_W-1:0] status,
                                input logic [SLOT_W-1:0] slot);
        int gap;
        int mark;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {tag, delay, now};
        do
            @(posedge clk);
        while (!s_tready);
        mark = due_results.size();
        predict_table(kind, now, delay, tag);
        if (typed)
        begin
            while (due_results.size() > mark)
                void'(due_results.pop_back());
            push_result(status, int'(slot), '0, 1'b1);
        end
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                           input logic [DELAY_W-1:0] delay, input logic [TAG_W-1:0] tag,
                           input int reps, input bit typed,
                           input logic [STATUS_W-1:0] status, input logic [SLOT_W-1:0] slot);
        request_row_t row;
        row.kind   = kind;
        row.now    = now;
        row.delay  = delay;
        row.tag    = tag;
        row.reps   = reps;
        row.typed  = typed;
        row.status = status;
        row.slot   = slot;
        directed_rows.push_back(row);
    endtask

    // result checker
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_seen <= beats_seen + 1;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected beat status=%0d slot=%0d tag=%h last=%b",
                         $time, m_tuser, m_tdata[5:0], m_tdata[21:6], m_tlast);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[5:0] !== want.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                             m_tdata[5:0]);
                    fail_count++;
                end
                if (m_tdata[21:6] !== want.tag)
                begin
                    $display("%0t: fired_tag expected %h actual %h", $time, want.tag,
                             m_tdata[21:6]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // receiver with random stalls and stall-free stretches
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ((beats_seen / 30) % 3 == 1) ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        logic [TIME_W-1:0]  clock_now;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] delay;
        logic [KIND_W-1:0]  kind;
        int                 pick;
        int                 sent;
        bit                 paused;

        fail_count = 0;
        beats_seen = 0;
        send_burst = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i]   = 1'b0;
            slot_due[i]    = '0;
            slot_handle[i] = '0;
        end
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;

        // kind, now, delay, tag, repeats, typed, status, slot
        add_row(KIND_TICK,     48'd0,    32'd0,        16'h0000, 1,  1, ST_NONE_DUE,  6'd0);
        add_row(KIND_CANCEL,   48'd0,    32'd0,        16'h0000, 1,  1, ST_CANCELLED, 6'd0);
        add_row(KIND_UNUSED,   48'd0,    32'd0,        16'h0000, 1,  0, ST_SCHEDULED, 6'd0);
        add_row(KIND_SCHEDULE, 48'd0,    32'hFFFF_FFFF, 16'hFFFF, 1, 1, ST_SCHEDULED, 6'd0);
        add_row(KIND_SCHEDULE, TIME_MAX, 32'h7FFF_FFFF, 16'h0000, 1, 1, ST_SCHEDULED, 6'd1);
        add_row(KIND_SCHEDULE, 48'd100,  32'h8000_0000, 16'h1234, 1, 1, ST_SCHEDULED, 6'd2);
        add_row(KIND_SCHEDULE, 48'd1000, 32'd500,      16'hA5A5, 1,  1, ST_SCHEDULED, 6'd3);
        add_row(KIND_TICK,     48'd0,    32'd0,        16'h0000, 1,  0, ST_SCHEDULED, 6'd0);
        add_row(KIND_TICK,     48'd1499, 32'd0,        16'h0000, 1,  1, ST_NONE_DUE,  6'd0);
        add_row(KIND_TICK,     48'd1500, 32'd0,        16'h0000, 1,  0, ST_SCHEDULED, 6'd0);
        add_row(KIND_SCHEDULE, 48'd2000, 32'd10,       16'h5555, 15, 0, ST_SCHEDULED, 6'd0);
        add_row(KIND_SCHEDULE, 48'd2000, 32'd10,       16'h6666, 1,  1, ST_DROPPED,   6'd0);
        add_row(KIND_TICK,     TIME_MAX, 32'd0,        16'h0000, 1,  0, ST_SCHEDULED, 6'd0);
        add_row(KIND_TICK,     48'd0,    32'd0,        16'h0000, 1,  1, ST_NONE_DUE,  6'd0);
        add_row(KIND_SCHEDULE, TIME_MAX - 48'd5, 32'd5, 16'h8001, 1, 1, ST_SCHEDULED, 6'd0);
        add_row(KIND_SCHEDULE, 48'd5,    32'hFFFF_FFFB, 16'h7FFE, 1, 1, ST_SCHEDULED, 6'd1);
        add_row(KIND_TICK,     48'd0,    32'd0,        16'h0000, 1,  0, ST_SCHEDULED, 6'd0);
        add_row(KIND_CANCEL,   TIME_MAX, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, ST_CANCELLED, 6'd0);
        add_row(KIND_TICK,     TIME_MAX, 32'd0,        16'h0000, 1,  1, ST_NONE_DUE,  6'd0);
        add_row(KIND_UNUSED,   TIME_MAX, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, ST_SCHEDULED, 6'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_request(directed_rows[r].kind, directed_rows[r].now,
                             directed_rows[r].delay, directed_rows[r].tag,
                             directed_rows[r].typed, directed_rows[r].status,
                             directed_rows[r].slot);
        end

        clock_now = 48'd10_000;
        sent      = 0;
        paused    = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            if (sent == RANDOM_REQUESTS / 2 && !paused)
            begin
                // hold off until the block has drained
                paused = 1;
                s_tvalid <= 1'b0;
                while (due_results.size() != 0)
                    @(posedge clk);
            end
            send_burst = ((sent / 40) % 3 == 2);
            clock_now  = clock_now + $urandom_range(0, 200);
            pick       = $urandom_range(0, 99);
            if ((sent / 50) % 2 == 0)
                pick = pick / 2 + (pick % 2) * 20;
            now   = ($urandom_range(0, 19) == 0) ? TIME_W'({$urandom, $urandom}) : clock_now;
            delay = $urandom;
            if (pick < 55)
            begin
                kind = KIND_SCHEDULE;
                case ($urandom_range(0, 19))
                    0:       delay = $urandom;
                    1:       delay = -$urandom_range(1, 500);
                    default: delay = $urandom_range(0, 1500);
                endcase
            end
            else if (pick < 90)
                kind = KIND_TICK;
            else if (pick < 95)
                kind = KIND_CANCEL;
            else
                kind = KIND_UNUSED;
            send_request(kind, now, delay, TAG_W'($urandom), 0, ST_SCHEDULED, 6'd0);
            if (kind != KIND_UNUSED)
                sent++;
        end
        s_tvalid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
